// ----- rtl/ssacf_pkg.sv -----
// shared types and constants for the stereo serial audio capture fifo
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ssacf_pkg;

    localparam int FIFO_DEPTH   = 512;
    localparam int FRAME_BITS   = 28;
    localparam int ADDR_W       = $clog2(FIFO_DEPTH);
    localparam int PHASE_W      = $clog2(FRAME_BITS);
    localparam int SAMPLE_W     = 24;
    localparam int SAMPLE_LSB   = 2;
    localparam int FRAME_BYTES  = 2 * SAMPLE_W / 8;
    localparam int PEND_W       = $clog2(FRAME_BYTES + 1);
    localparam int LIMIT_W      = 9;
    localparam int LEFT_BIT     = 6;
    localparam int RIGHT_BIT    = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(258);

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic {
        CFG_ENABLE = 1'b0,
        CFG_LIMIT  = 1'b1
    } cfg_index_t;

    // one finished stereo frame from the deserializer
    typedef struct packed {
        logic                    done;
        logic [2*SAMPLE_W-1:0]   word;   // right sample high, left sample low
    } frame_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_item_t;

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] i);
        next_index = (i == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/stereo_serial_audio_capture_fifo_unit.sv -----
// stereo serial audio capture with an overwrite byte ring fifo (top level)
// depends on ssacf_pkg and ssacf_deser
//
// Usage: each input item carries an action in s_tuser and a port byte in s_tdata.
// A port sample shifts bit 6 into the left frame and bit 7 into the right frame;
// every 28th sample ends a frame and six bytes (left low..high, right low..high)
// go into a 512-byte ring. A full ring drops its oldest byte. A read item returns
// one result on the m_ channel: the byte, a valid flag in m_tuser and the packet
// end in m_tlast (an empty ring gives valid 0, last 1). A restart clears pointers,
// bit phase and packet count. Registers are written through the cfg_ channel:
// index 0 capture enable, index 1 packet limit.
// Throughput: one item per cycle while s_tready is high. The six bytes of a frame are
// written one after another after its last sample through the single memory write
// port; samples keep flowing then, but a read waits until those writes are done. A
// read result shows on m_tvalid once it has passed the memory read register and then
// a two-entry output queue. When the receiver stalls the queue fills and s_tready
// drops for reads only. After aresetn the ring is empty, capture is off and the
// packet limit is 258; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stereo_serial_audio_capture_fifo_unit
    import ssacf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input item
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // port_bits
    input  wire logic [1:0]          s_tuser,   // action
    // result item
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // data_byte
    output logic                     m_tuser,   // byte_valid
    output logic                     m_tlast,   // packet_last
    // register writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [LIMIT_W-1:0]  cfg_data
);

    action_t               act;
    logic                  in_fire, do_sample, do_read, do_restart;
    logic                  read_ok, drain, pop;
    frame_t                frame;

    logic                  enable_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic [ADDR_W-1:0]     wr_reg, wr_next;
    logic [ADDR_W-1:0]     rd_reg, rd_next;
    logic [ADDR_W-1:0]     wr_inc, rd_inc;
    logic [LIMIT_W-1:0]    pkt_reg, pkt_next, pkt_inc;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [2*SAMPLE_W-1:0] stage_reg, stage_next;
    logic                  hit, last;

    logic [7:0]            mem [FIFO_DEPTH];
    logic [7:0]            rdata_reg;

    logic                  p1_reg;
    logic                  p1_hit_reg, p1_last_reg;

    out_item_t             oq [2];
    logic                  oq_wp_reg, oq_rp_reg;
    logic [1:0]            occ_reg, occ_next;
    out_item_t             oq_in;

    assign act       = action_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign drain     = (pend_reg != '0);
    assign pop       = m_tvalid && m_tready;
    // room for one more result counting the read in flight
    assign read_ok   = !drain && (((2'(occ_reg) + 2'(p1_reg)) < 2'd2) || pop);
    assign s_tready  = (act != ACT_READ) || read_ok;
    assign in_fire   = s_tvalid && s_tready;
    assign do_sample  = in_fire && (act == ACT_SAMPLE) && enable_reg;
    assign do_read    = in_fire && (act == ACT_READ);
    assign do_restart = in_fire && (act == ACT_RESTART);

    ssacf_deser u_deser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sample_en (do_sample),
        .clear     (do_restart),
        .port_bits (s_tdata),
        .frame     (frame)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_LIMIT:  limit_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pointer, packet and drain bookkeeping
    always_comb begin
        wr_inc     = next_index(wr_reg);
        rd_inc     = next_index(rd_reg);
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        pkt_next   = pkt_reg;
        pend_next  = pend_reg;
        stage_next = stage_reg;
        hit        = (rd_reg != wr_reg);
        pkt_inc    = pkt_reg + 1'b1;
        last       = 1'b1;
        if (hit) begin
            last = (pkt_inc >= limit_reg) || (rd_inc == wr_reg);
        end
        priority if (do_restart) begin
            wr_next   = '0;
            rd_next   = '0;
            pkt_next  = '0;
            pend_next = '0;
        end else if (drain) begin
            wr_next    = wr_inc;
            // full ring: drop the oldest byte
            rd_next    = (wr_inc == rd_reg) ? rd_inc : rd_reg;
            pend_next  = pend_reg - 1'b1;
            stage_next = stage_reg >> 8;
        end else if (do_read) begin
            if (hit) begin
                rd_next = rd_inc;
            end
            pkt_next = last ? '0 : pkt_inc;
        end
        if (frame.done) begin
            pend_next  = PEND_W'(FRAME_BYTES);
            stage_next = frame.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            pkt_reg  <= '0;
            pend_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            pkt_reg  <= pkt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

    // byte ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (drain && !do_restart) begin
            mem[wr_reg] <= stage_reg[7:0];
        end
        if (do_read) begin
            rdata_reg <= mem[rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= 1'b0;
        end else begin
            p1_reg <= do_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_read) begin
            p1_hit_reg  <= hit;
            p1_last_reg <= last;
        end
    end

    // two-entry output queue
    always_comb begin
        oq_in.data  = p1_hit_reg ? rdata_reg : 8'd0;
        oq_in.valid = p1_hit_reg;
        oq_in.last  = p1_last_reg;
        occ_next    = occ_reg + 2'(p1_reg) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wp_reg <= 1'b0;
            oq_rp_reg <= 1'b0;
            occ_reg   <= '0;
        end else begin
            if (p1_reg) begin
                oq_wp_reg <= ~oq_wp_reg;
            end
            if (pop) begin
                oq_rp_reg <= ~oq_rp_reg;
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_reg) begin
            oq[oq_wp_reg] <= oq_in;
        end
    end

    assign m_tvalid = (occ_reg != '0);
    assign m_tdata  = oq[oq_rp_reg].data;
    assign m_tuser  = oq[oq_rp_reg].valid;
    assign m_tlast  = oq[oq_rp_reg].last;

    // output queue never holds more than two items
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 2'd2)
        else $error("output queue overflow");

    // a read is never accepted while frame bytes are still being written
    a_read_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        do_read |-> (pend_reg == '0))
        else $error("read accepted during drain");

    // a new frame never lands on an unfinished drain
    a_frame_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        frame.done |-> (pend_reg == '0))
        else $error("frame finished while drain pending");

    // an empty-ring result is a zero byte that ends the packet
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("bad empty read result");

endmodule

`default_nettype wire

// ----- rtl/ssacf_deser.sv -----
// serial audio deserializer: left and right frame shift registers and bit phase
// depends on ssacf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssacf_deser
    import ssacf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        sample_en,
    input  wire logic        clear,
    input  wire logic [7:0]  port_bits,
    output frame_t           frame
);

    logic [FRAME_BITS-1:0] left_reg,  left_next;
    logic [FRAME_BITS-1:0] right_reg, right_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  wrap;

    always_comb begin
        left_next  = {left_reg[FRAME_BITS-2:0],  port_bits[LEFT_BIT]};
        right_next = {right_reg[FRAME_BITS-2:0], port_bits[RIGHT_BIT]};
        wrap       = (phase_reg == PHASE_W'(FRAME_BITS - 1));
        phase_next = wrap ? '0 : phase_reg + 1'b1;
        frame.done = sample_en && wrap;
        frame.word = {right_next[SAMPLE_LSB+SAMPLE_W-1:SAMPLE_LSB],
                      left_next[SAMPLE_LSB+SAMPLE_W-1:SAMPLE_LSB]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            left_reg  <= '0;
            right_reg <= '0;
            phase_reg <= '0;
        end else if (sample_en) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for stereo_serial_audio_capture_fifo_unit
// depends on ssacf_pkg and the rtl of the block; item-level predictor runs alongside
// directed table first, then random phases and a receiver hold-off
`timescale 1ns / 1ps

module tb;
    import ssacf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } read_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   act;
        cfg_index_t   sel;
        logic [8:0]   val;
        logic [11:0]  reps;
        logic         typed;
        read_result_t want;
    } plan_row_t;

    localparam read_result_t NONE       = '0;
    localparam read_result_t EMPTY_READ = '{8'h00, 1'b0, 1'b1};
    localparam read_result_t FF_MORE    = '{8'hFF, 1'b1, 1'b0};
    localparam read_result_t FF_END     = '{8'hFF, 1'b1, 1'b1};
    localparam read_result_t ZERO_END   = '{8'h00, 1'b1, 1'b1};

    localparam int PLAN_ROWS = 28;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // capture off after reset: empty ring, samples ignored, unused code ignored
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, EMPTY_READ},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h0C0, 12'd28, 1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, EMPTY_READ},
        '{ROW_ITEM, ACT_UNUSED,  CFG_ENABLE, 9'h0FF, 12'd1,  1'b0, NONE},
        '{ROW_REG,  ACT_SAMPLE,  CFG_ENABLE, 9'd1,   12'd0,  1'b0, NONE},
        // all-ones frame, drained with the default limit: last only when empty
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h0C0, 12'd28, 1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd5,  1'b1, FF_MORE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, FF_END},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, EMPTY_READ},
        // limit one: every byte ends a packet
        '{ROW_REG,  ACT_SAMPLE,  CFG_LIMIT,  9'd1,   12'd0,  1'b0, NONE},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h040, 12'd28, 1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd3,  1'b1, FF_END},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd3,  1'b1, ZERO_END},
        // limit zero behaves as one
        '{ROW_REG,  ACT_SAMPLE,  CFG_LIMIT,  9'd0,   12'd0,  1'b0, NONE},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h080, 12'd28, 1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd3,  1'b1, ZERO_END},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd3,  1'b1, FF_END},
        // restart in mid frame realigns the bit phase
        '{ROW_REG,  ACT_SAMPLE,  CFG_LIMIT,  9'd511, 12'd0,  1'b0, NONE},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h03F, 12'd13, 1'b0, NONE},
        '{ROW_ITEM, ACT_RESTART, CFG_ENABLE, 9'h0FF, 12'd1,  1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, EMPTY_READ},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h055, 12'd14, 1'b0, NONE},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h0AA, 12'd14, 1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd7,  1'b0, NONE},
        '{ROW_REG,  ACT_SAMPLE,  CFG_LIMIT,  9'd258, 12'd0,  1'b0, NONE},
        '{ROW_REG,  ACT_SAMPLE,  CFG_ENABLE, 9'd0,   12'd0,  1'b0, NONE},
        '{ROW_ITEM, ACT_SAMPLE,  CFG_ENABLE, 9'h0FF, 12'd5,  1'b0, NONE},
        '{ROW_ITEM, ACT_READ,    CFG_ENABLE, 9'h000, 12'd1,  1'b1, EMPTY_READ}
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [LIMIT_W-1:0]  cfg_data = '0;

    // sideband that travels with each item: a typed expectation from the table
    logic                item_typed = 1'b0;
    read_result_t        item_want = '0;

    stereo_serial_audio_capture_fifo_unit DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // capture predictor state
    logic [7:0]             ring [FIFO_DEPTH];
    logic [ADDR_W-1:0]      wr_ptr = '0;
    logic [ADDR_W-1:0]      rd_ptr = '0;
    int unsigned            frame_phase = 0;
    logic [FRAME_BITS-1:0]  left_frame = '0;
    logic [FRAME_BITS-1:0]  right_frame = '0;
    logic [LIMIT_W-1:0]     pkt_count = '0;
    logic                   cap_en = 1'b0;
    logic [LIMIT_W-1:0]     pkt_limit = LIMIT_RESET;

    read_result_t expected_bytes [$];

    int unsigned cycles = 0, mismatches = 0, items_in = 0, frames_seen = 0, dropped = 0;
    int unsigned reads_seen = 0, bytes_seen = 0, ends_seen = 0;
    int unsigned burst_left = 0, holds_asked = 0, holds_done = 0;
    bit          steady = 1'b0;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void ring_push(input logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr = ring_next(wr_ptr);
        // full ring: oldest byte is lost
        if (wr_ptr == rd_ptr) begin
            rd_ptr = ring_next(rd_ptr);
            dropped++;
        end
    endfunction

    function automatic void push_sample(input logic [FRAME_BITS-1:0] frame);
        logic [SAMPLE_W-1:0] s;
        s = frame[SAMPLE_LSB +: SAMPLE_W];
        ring_push(s[7:0]);
        ring_push(s[15:8]);
        ring_push(s[23:16]);
    endfunction

    // returns 1 when the item produces a read result
    function automatic bit capture_step(input logic [1:0] act, input logic [7:0] bits,
                                        output read_result_t res);
        res = '0;
        case (act)
            ACT_SAMPLE: begin
                if (cap_en) begin
                    left_frame  = {left_frame[FRAME_BITS-2:0], bits[LEFT_BIT]};
                    right_frame = {right_frame[FRAME_BITS-2:0], bits[RIGHT_BIT]};
                    if (frame_phase == FRAME_BITS - 1) begin
                        frame_phase = 0;
                        push_sample(left_frame);
                        push_sample(right_frame);
                        frames_seen++;
                    end else begin
                        frame_phase++;
                    end
                end
                return 1'b0;
            end
            ACT_READ: begin
                res.last = 1'b1;
                if (rd_ptr != wr_ptr) begin
                    res.data  = ring[rd_ptr];
                    res.valid = 1'b1;
                    rd_ptr    = ring_next(rd_ptr);
                    pkt_count = pkt_count + 1'b1;
                    res.last  = (pkt_count >= pkt_limit) || (rd_ptr == wr_ptr);
                end
                if (res.last)
                    pkt_count = '0;
                return 1'b1;
            end
            ACT_RESTART: begin
                wr_ptr      = '0;
                rd_ptr      = '0;
                frame_phase = 0;
                left_frame  = '0;
                right_frame = '0;
                pkt_count   = '0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // predictor update, result check and watchdog
    always @(posedge aclk) begin
        read_result_t res, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("stereo_serial_audio_capture_fifo_unit: mismatch");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ENABLE)
                    cap_en = cfg_data[0];
                else
                    pkt_limit = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                items_in++;
                if (capture_step(s_tuser, s_tdata, res))
                    expected_bytes.push_back(item_typed ? item_want : res);
            end
            if (m_tvalid && m_tready) begin
                reads_seen++;
                bytes_seen += m_tuser;
                ends_seen  += m_tlast;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read %0d: unexpected result data %02h valid %0b last %0b",
                                 reads_seen, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tuser !== want.valid
                        || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("read %0d: expected data %02h valid %0b last %0b, %s",
                                     reads_seen, want.data, want.valid, want.last,
                                     $sformatf("got data %02h valid %0b last %0b",
                                               m_tdata, m_tuser, m_tlast));
                    end
                end
            end
        end
    end

    // receiver: stall pattern that changes mode now and then, plus requested hold-offs
    typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY } rx_mode_t;
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned mode_left = 0, rx_tick = 0, hold_left = 0;

    always @(posedge aclk) begin
        logic ready_next;
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   ready_next = 1'b1;
                RX_COIN:   ready_next = $urandom_range(0, 1);
                RX_SPARSE: ready_next = (rx_tick % 4 == 0);
                default:   ready_next = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_tready <= ready_next;
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] bits,
                             input logic typed, input read_result_t want);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 && !steady) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= bits;
        item_typed <= typed;
        item_want  <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait for every expected result, then let trailing frame writes finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [LIMIT_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int i, ph, pick, run, done_items;
        logic [LIMIT_W-1:0] lim;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < PLAN_ROWS; i++) begin
            if (PLAN[i].kind == ROW_REG)
                write_reg(PLAN[i].sel, PLAN[i].val);
            else
                repeat (PLAN[i].reps)
                    send_item(PLAN[i].act, PLAN[i].val[7:0], PLAN[i].typed, PLAN[i].want);
        end

        // random phases: runs of samples and reads, occasional restart and unused code
        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0, 1:    lim = $urandom_range(1, 12);
                2:       lim = $urandom_range(13, 258);
                default: lim = $urandom_range(0, 511);
            endcase
            write_reg(CFG_LIMIT, lim);
            write_reg(CFG_ENABLE, LIMIT_W'($urandom_range(0, 5) != 0));
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    run = $urandom_range(1, 2 * FRAME_BITS);
                    repeat (run) send_item(ACT_SAMPLE, 8'($urandom), 1'b0, NONE);
                    done_items += run;
                end else if (pick < 94) begin
                    run = $urandom_range(1, 12);
                    repeat (run) send_item(ACT_READ, 8'($urandom), 1'b0, NONE);
                    done_items += run;
                end else if (pick < 98) begin
                    send_item(ACT_RESTART, 8'($urandom), 1'b0, NONE);
                    done_items++;
                end else begin
                    send_item(ACT_UNUSED, 8'($urandom), 1'b0, NONE);
                end
            end
        end

        // receiver holds off while reads keep coming, so the output queue backs up
        write_reg(CFG_ENABLE, 9'd1);
        write_reg(CFG_LIMIT, LIMIT_W'($urandom_range(2, 9)));
        steady = 1'b1;
        holds_asked++;
        repeat (120)
            send_item(($urandom_range(0, 9) < 6) ? ACT_READ : ACT_SAMPLE,
                      8'($urandom), 1'b0, NONE);
        steady = 1'b0;

        settle();
        repeat (20) @(posedge aclk);
        mismatches += expected_bytes.size();

        $display("covered %0d items: %0d frames captured, %0d bytes dropped on overflow",
                 items_in, frames_seen, dropped);
        $display("checked %0d reads: %0d bytes, %0d packet ends, %0d failures",
                 reads_seen, bytes_seen, ends_seen, mismatches);
        if (mismatches == 0)
            $display("stereo_serial_audio_capture_fifo_unit: match");
        else
            $display("stereo_serial_audio_capture_fifo_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssacf_pkg.sv
rtl/ssacf_deser.sv
rtl/stereo_serial_audio_capture_fifo_unit.sv
tb/tb.sv
